[rtl/core/gcps_pkg.sv]
// shared types, opcodes and command length table for the gpu command port core
`default_nettype none
package gcps_pkg;

   localparam int ReqDataWidth = 32;
   localparam int ReqUserWidth = 2;
   localparam int RspDataWidth = 104;
   localparam int QueueDepth = 2;

   typedef enum logic [1:0] {
      KIND_GP0  = 2'd0,
      KIND_GP1  = 2'd1,
      KIND_POLL = 2'd2
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] data;
   } item_type;

   typedef struct packed {
      logic       known;
      logic [3:0] len;
   } length_type;

   localparam logic [7:0] OP_NOP      = 8'h00;
   localparam logic [7:0] OP_CLEAR    = 8'h01;
   localparam logic [7:0] OP_POLY3    = 8'h28;
   localparam logic [7:0] OP_POLY4T   = 8'h2c;
   localparam logic [7:0] OP_POLY3G   = 8'h30;
   localparam logic [7:0] OP_POLY4G   = 8'h38;
   localparam logic [7:0] OP_IMG_LOAD = 8'ha0;
   localparam logic [7:0] OP_IMG_SAVE = 8'hc0;
   localparam logic [7:0] OP_DRAW_MODE = 8'he1;
   localparam logic [7:0] OP_TEX_WIN  = 8'he2;
   localparam logic [7:0] OP_AREA_TL  = 8'he3;
   localparam logic [7:0] OP_AREA_BR  = 8'he4;
   localparam logic [7:0] OP_OFFSET   = 8'he5;
   localparam logic [7:0] OP_MASK     = 8'he6;

   localparam logic [7:0] GP1_INIT      = 8'h00;
   localparam logic [7:0] GP1_FLUSH     = 8'h01;
   localparam logic [7:0] GP1_IRQ_ACK   = 8'h02;
   localparam logic [7:0] GP1_DISP_EN   = 8'h03;
   localparam logic [7:0] GP1_DMA_DIR   = 8'h04;
   localparam logic [7:0] GP1_VRAM_ST   = 8'h05;
   localparam logic [7:0] GP1_HRANGE    = 8'h06;
   localparam logic [7:0] GP1_VRANGE    = 8'h07;
   localparam logic [7:0] GP1_DISP_MODE = 8'h08;

   function automatic length_type gp0_length(input logic [7:0] op);
      length_type r;
      r.known = 1'b1;
      unique case (op)
         OP_NOP, OP_CLEAR, OP_DRAW_MODE, OP_TEX_WIN,
         OP_AREA_TL, OP_AREA_BR, OP_OFFSET, OP_MASK: r.len = 4'd1;
         OP_POLY3G: r.len = 4'd6;
         OP_POLY4T: r.len = 4'd9;
         OP_IMG_LOAD, OP_IMG_SAVE: r.len = 4'd3;
         OP_POLY3: r.len = 4'd5;
         OP_POLY4G: r.len = 4'd8;
         default: begin
            r.len = 4'd1;
            r.known = 1'b0;
         end
      endcase
      return r;
   endfunction

endpackage
`default_nettype wire

[rtl/core/gcps_front.sv]
// front end: accepts and classifies port accesses into a short queue
`default_nettype none
module gcps_front
   import gcps_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [ReqUserWidth-1:0] req_tuser,  // access_kind
   input  wire logic [ReqDataWidth-1:0] req_tdata,  // data_word
   output logic                         item_valid,
   output item_type                     item,
   input  wire logic                    item_pop
);
   localparam int PtrW = $clog2(QueueDepth);
   localparam int CntW = $clog2(QueueDepth + 1);

   item_type            queue_ff [QueueDepth];
   logic [PtrW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [CntW-1:0]     count_ff;
   item_type            incoming;
   logic                push, pop;

   always_comb begin
      incoming.data = req_tdata;
      unique case (req_tuser)
         2'd0: incoming.kind = KIND_GP0;
         2'd1: incoming.kind = KIND_GP1;
         default: incoming.kind = KIND_POLL;
      endcase
   end

   assign req_tready = (count_ff != CntW'(QueueDepth));
   assign push = req_tvalid && req_tready;
   assign item_valid = (count_ff != '0);
   assign pop = item_pop && item_valid;
   assign item = queue_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= incoming;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PtrW'(QueueDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + CntW'(push) - CntW'(pop);
      end
   end

`ifndef SYNTHESIS
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CntW'(QueueDepth)) else $error("queue count overflow");
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      (count_ff == CntW'(QueueDepth)) |-> !push) else $error("push into full queue");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 1'b1)) else $error("count step");
`endif
endmodule
`default_nettype wire

[rtl/core/gcps_back.sv]
// back end: command framing, draw and display state, status packing, result register
`default_nettype none
module gcps_back
   import gcps_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    item_valid,
   input  wire item_type                item,
   output logic                         item_pop,
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   output logic [RspDataWidth-1:0]      rsp_tdata
);
   logic [3:0]  page_x_ff, page_x_in;
   logic        page_y_ff, page_y_in;
   logic [1:0]  semi_ff, semi_in;
   logic [1:0]  tdepth_ff, tdepth_in;
   logic [4:0]  dflags_ff, dflags_in;
   logic [1:0]  mask_ff, mask_in;
   logic [19:0] twin_ff, twin_in;
   logic [61:0] area_ff, area_in;
   logic [7:0]  mode_ff, mode_in;
   logic [3:0]  dctl_ff, dctl_in;
   logic [18:0] vram_ff, vram_in;
   logic [43:0] ranges_ff, ranges_in;
   logic        img_ff, img_in;
   logic [31:0] remain_ff, remain_in;
   logic [7:0]  pend_ff, pend_in;
   logic        pend_unk_ff, pend_unk_in;
   logic [3:0]  pos_ff, pos_in;
   logic        valid_ff;
   logic [RspDataWidth-1:0] data_ff, data_in;

   logic        done, imgw, unk, badm, vp_chk, vp_ok;
   logic [7:0]  dop, op;
   logic [31:0] v, remain_dec, prod, status;
   logic [3:0]  pos_cur;
   length_type  len;
   logic        first;
   logic [15:0] vw, vh, vx, vy;
   logic [1:0]  dma;

   assign item_pop = item_valid && (!valid_ff || rsp_tready);
   assign v = item.data;
   assign prod = v[15:0] * v[31:16];

   always_comb begin
      page_x_in = page_x_ff; page_y_in = page_y_ff; semi_in = semi_ff;
      tdepth_in = tdepth_ff; dflags_in = dflags_ff; mask_in = mask_ff;
      twin_in = twin_ff; area_in = area_ff; mode_in = mode_ff; dctl_in = dctl_ff;
      vram_in = vram_ff; ranges_in = ranges_ff; img_in = img_ff;
      remain_in = remain_ff; pend_in = pend_ff; pend_unk_in = pend_unk_ff;
      pos_in = pos_ff;
      done = 1'b0; imgw = 1'b0; unk = 1'b0; badm = 1'b0; vp_chk = 1'b0; dop = '0;
      first = (remain_ff == '0);
      op = first ? v[31:24] : pend_ff;
      len = gp0_length(v[31:24]);
      remain_dec = (first ? 32'(len.len) : remain_ff) - 32'd1;
      pos_cur = first ? 4'd0 : pos_ff;
      unique case (item.kind)
         KIND_GP0: begin
            if (first) begin
               pend_in = v[31:24];
               pend_unk_in = !len.known;
            end
            remain_in = remain_dec;
            pos_in = pos_cur;
            if (img_ff) begin
               imgw = 1'b1;
               if (remain_dec == '0) begin
                  img_in = 1'b0;
               end
            end else begin
               if (pos_cur != 4'd15) begin
                  pos_in = pos_cur + 4'd1;
               end
               if (remain_dec == '0) begin
                  if (first ? !len.known : pend_unk_ff) begin
                     unk = 1'b1;
                     pend_in = '0;
                     pend_unk_in = 1'b0;
                  end else begin
                     done = 1'b1;
                     dop = op;
                     unique case (op)
                        OP_DRAW_MODE: begin
                           page_x_in = v[3:0];
                           page_y_in = v[4];
                           semi_in = v[6:5];
                           if (v[8:7] != 2'd3) begin
                              tdepth_in = v[8:7];
                           end
                           dflags_in = v[13:9];
                        end
                        OP_TEX_WIN: twin_in = v[19:0];
                        OP_AREA_TL: area_in[19:0] = v[19:0];
                        OP_AREA_BR: area_in[39:20] = v[19:0];
                        OP_OFFSET: area_in[61:40] = v[21:0];
                        OP_MASK: mask_in = v[1:0];
                        OP_IMG_LOAD: begin
                           if (prod[31:1] != '0 || prod[0]) begin
                              remain_in = {1'b0, prod[31:1]} + 32'(prod[0]);
                              img_in = 1'b1;
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
         end
         KIND_GP1: begin
            unique case (v[31:24])
               GP1_INIT: begin
                  remain_in = '0; img_in = 1'b0; pos_in = '0;
                  page_x_in = '0; page_y_in = 1'b0; semi_in = '0; tdepth_in = '0;
                  dflags_in = '0; mask_in = '0; twin_in = '0; area_in = '0;
                  mode_in = {mode_ff[7], 7'h40};
                  dctl_in = 4'd1;
                  vram_in = '0;
                  ranges_in = {10'h100, 10'h010, 12'hc00, 12'h200};
               end
               GP1_FLUSH: begin
                  remain_in = '0; img_in = 1'b0; pos_in = '0;
               end
               GP1_IRQ_ACK: dctl_in[1] = 1'b0;
               GP1_DISP_EN: dctl_in[0] = v[0];
               GP1_DMA_DIR: dctl_in[3:2] = v[1:0];
               GP1_VRAM_ST: begin
                  vram_in = {v[18:10], v[9:1], 1'b0};
                  vp_chk = 1'b1;
               end
               GP1_HRANGE: begin
                  ranges_in[23:0] = v[23:0];
                  vp_chk = 1'b1;
               end
               GP1_VRANGE: begin
                  ranges_in[43:24] = v[19:0];
                  vp_chk = 1'b1;
               end
               GP1_DISP_MODE: begin
                  mode_in = {mode_ff[7], v[5:2], v[1:0], v[6]};
                  badm = v[7];
               end
               default: unk = 1'b1;
            endcase
         end
         default: ;
      endcase

      vw = 16'(ranges_in[23:12]) - 16'(ranges_in[11:0]);
      vh = 16'(ranges_in[43:34]) - 16'(ranges_in[33:24]);
      vx = 16'(vram_in[9:0]) + (16'(ranges_in[11:0]) - 16'h0200);
      vy = 16'(vram_in[18:10]) + 16'(ranges_in[33:24]);
      vp_ok = vp_chk && vw != '0 && vw <= 16'd1024 && vh != '0 && vh <= 16'd512;

      dma = dctl_in[3:2];
      status = {1'b0, dma, 3'b111, (dma != 2'd0), dctl_in[1:0], mode_in[6:4], 1'b0,
                mode_in[2:0], dflags_in[2], 1'b0, mode_in[7], mask_in, dflags_in[1],
                dflags_in[0], tdepth_in, semi_in, page_y_in, page_x_in};
      data_in = {6'd0,
                 vp_ok ? vh[9:0] : 10'd0, vp_ok ? vw[10:0] : 11'd0,
                 vp_ok ? vy : 16'd0, vp_ok ? vx : 16'd0, vp_ok,
                 badm, unk, imgw, dop, done, status};
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;

   always_ff @(posedge clock) begin
      if (item_pop) begin
         data_ff <= data_in;
      end
      if (reset) begin
         valid_ff <= 1'b0;
         mode_ff <= 8'hc0;
         dctl_ff <= 4'd1;
         ranges_ff <= {10'h100, 10'h010, 12'hc00, 12'h200};
         img_ff <= 1'b0;
         remain_ff <= '0;
         pos_ff <= '0;
         page_x_ff <= '0; page_y_ff <= 1'b0; semi_ff <= '0; tdepth_ff <= '0;
         dflags_ff <= '0; mask_ff <= '0; twin_ff <= '0; area_ff <= '0;
         vram_ff <= '0; pend_ff <= '0; pend_unk_ff <= 1'b0;
      end else begin
         if (item_pop) begin
            valid_ff <= 1'b1;
            mode_ff <= mode_in; dctl_ff <= dctl_in; ranges_ff <= ranges_in;
            img_ff <= img_in; remain_ff <= remain_in; pos_ff <= pos_in;
            page_x_ff <= page_x_in; page_y_ff <= page_y_in; semi_ff <= semi_in;
            tdepth_ff <= tdepth_in; dflags_ff <= dflags_in; mask_ff <= mask_in;
            twin_ff <= twin_in; area_ff <= area_in; vram_ff <= vram_in;
            pend_ff <= pend_in; pend_unk_ff <= pend_unk_in;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

`ifndef SYNTHESIS
   a_img_has_words: assert property (@(posedge clock) disable iff (reset)
      img_ff |-> (remain_ff != '0)) else $error("image load with no words left");
   a_flags_exclusive: assert property (@(posedge clock) disable iff (reset)
      valid_ff |-> !(data_ff[32] && (data_ff[41] || data_ff[42])))
      else $error("done with image or unknown");
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && !rsp_tready) |-> !item_pop) else $error("pop while result stalled");
`endif
endmodule
`default_nettype wire

[rtl/core/gpu_command_port_and_status_core.sv]
// top level of the gpu command port and status core
`default_nettype none
// GP0, GP1 and status-poll accesses enter on req_ and each gives exactly one
// result on rsp_ carrying the status word after that access, command framing
// flags and any new display window. One access is taken per clock while the
// two-entry queue is not full; the queue decouples the front end from the back
// end, whose framing counter, state update and 16x16 image-size multiply are
// combinational; the back end stalls while a result in its register waits.
module gpu_command_port_and_status_core
   import gcps_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   output logic                         req_tready,
   input  wire logic [ReqUserWidth-1:0] req_tuser,  // access_kind
   input  wire logic [ReqDataWidth-1:0] req_tdata,  // data_word
   output logic                         rsp_tvalid,
   input  wire logic                    rsp_tready,
   // status_word, command_done, done_opcode, image_data_word, unknown_command,
   // bad_display_mode, viewport_update, viewport_x, viewport_y, viewport_width,
   // viewport_height
   output logic [RspDataWidth-1:0]      rsp_tdata
);
   logic     item_valid, item_pop;
   item_type item;

   gcps_front u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tuser(req_tuser),
      .req_tdata(req_tdata),
      .item_valid(item_valid), .item(item), .item_pop(item_pop)
   );

   gcps_back u_back (
      .clock(clock), .reset(reset),
      .item_valid(item_valid), .item(item), .item_pop(item_pop),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata)
   );
endmodule
`default_nettype wire

[dv/gpu_command_port_and_status_checker.sv]
// checker that predicts and compares every status result of the gpu command port core
`default_nettype none
module gpu_command_port_and_status_checker
   import gcps_pkg::*;
(
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    req_tvalid,
   input  wire logic                    req_tready,
   input  wire logic [ReqUserWidth-1:0] req_tuser,
   input  wire logic [ReqDataWidth-1:0] req_tdata,
   input  wire logic                    rsp_tvalid,
   input  wire logic                    rsp_tready,
   input  wire logic [RspDataWidth-1:0] rsp_tdata,
   output int                           fail_count,
   output int                           awaited_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [9:0]  vp_h;
      logic [10:0] vp_w;
      logic [15:0] vp_y;
      logic [15:0] vp_x;
      logic        vp_upd;
      logic        bad_mode;
      logic        unk;
      logic        img;
      logic [7:0]  op;
      logic        done;
      logic [31:0] status;
   } gpu_result_type;

   logic [3:0]  page_x;
   logic        page_y;
   logic [1:0]  semi;
   logic [1:0]  tex_depth;
   logic [4:0]  draw_bits;
   logic [1:0]  mask_bits;
   logic [7:0]  disp_mode;
   logic [3:0]  off_irq_dma;
   logic [18:0] vram_start;
   logic [43:0] ranges;
   logic        image_mode;
   logic [31:0] words_left;
   logic [7:0]  cmd_op;
   logic        cmd_unknown;
   logic [3:0]  word_pos;
   logic [31:0] image_size;

   gpu_result_type status_expected_q[$];

   task automatic clear_gpu_state();
      words_left = '0; image_mode = 1'b0; word_pos = '0;
      page_x = '0; page_y = 1'b0; semi = '0; tex_depth = '0; draw_bits = '0;
      mask_bits = '0;
      disp_mode = (disp_mode & 8'h80) | 8'h40;
      off_irq_dma = 4'h1;
      vram_start = '0;
      ranges = {10'h100, 10'h010, 12'hc00, 12'h200};
   endtask

   function automatic logic [31:0] gpu_status_word();
      logic [31:0] r;
      r = '0;
      r[3:0] = page_x; r[4] = page_y; r[6:5] = semi; r[8:7] = tex_depth;
      r[9] = draw_bits[0]; r[10] = draw_bits[1]; r[12:11] = mask_bits;
      r[13] = disp_mode[7]; r[15] = draw_bits[2]; r[18:16] = disp_mode[2:0];
      r[20] = disp_mode[4]; r[21] = disp_mode[5]; r[22] = disp_mode[6];
      r[24:23] = off_irq_dma[1:0]; r[25] = |off_irq_dma[3:2]; r[28:26] = 3'b111;
      r[30:29] = off_irq_dma[3:2];
      return r;
   endfunction

   task automatic compute_window(inout gpu_result_type res);
      logic [15:0] hs, he, ls, le, w, h;
      hs = 16'(ranges[11:0]); he = 16'(ranges[23:12]);
      ls = 16'(ranges[33:24]); le = 16'(ranges[43:34]);
      w = he - hs; h = le - ls;
      if (w != 0 && w <= 1024 && h != 0 && h <= 512) begin
         res.vp_upd = 1'b1;
         res.vp_x = 16'(vram_start[9:0]) + (hs - 16'h0200);
         res.vp_y = 16'(vram_start[18:10]) + ls;
         res.vp_w = w[10:0];
         res.vp_h = h[9:0];
      end
   endtask

   task automatic gp0_word(input logic [31:0] v, inout gpu_result_type res);
      logic [31:0] pixels;
      if (words_left == 0) begin
         cmd_op = v[31:24];
         cmd_unknown = 1'b0;
         case (cmd_op)
            OP_NOP, OP_CLEAR, OP_DRAW_MODE, OP_TEX_WIN, OP_AREA_TL, OP_AREA_BR,
            OP_OFFSET, OP_MASK: words_left = 32'd1;
            OP_POLY3G: words_left = 32'd6;
            OP_POLY4T: words_left = 32'd9;
            OP_IMG_LOAD, OP_IMG_SAVE: words_left = 32'd3;
            OP_POLY3: words_left = 32'd5;
            OP_POLY4G: words_left = 32'd8;
            default: begin
               words_left = 32'd1;
               cmd_unknown = 1'b1;
            end
         endcase
         word_pos = '0;
      end
      words_left = words_left - 32'd1;
      if (image_mode) begin
         res.img = 1'b1;
         if (words_left == 0) image_mode = 1'b0;
         return;
      end
      if (word_pos == 2) image_size = v;
      if (word_pos < 15) word_pos = word_pos + 4'd1;
      if (words_left != 0) return;
      if (cmd_unknown) begin
         res.unk = 1'b1;
         cmd_unknown = 1'b0;
         return;
      end
      res.done = 1'b1;
      res.op = cmd_op;
      case (cmd_op)
         OP_DRAW_MODE: begin
            page_x = v[3:0]; page_y = v[4]; semi = v[6:5];
            if (v[8:7] != 2'd3) tex_depth = v[8:7];
            draw_bits = v[13:9];
         end
         OP_MASK: mask_bits = v[1:0];
         OP_IMG_LOAD: begin
            pixels = 32'(image_size[15:0]) * 32'(image_size[31:16]);
            pixels = ((pixels + 32'd1) & ~32'd1) / 32'd2;
            if (pixels != 0) begin
               words_left = pixels;
               image_mode = 1'b1;
            end
         end
         default: ;
      endcase
   endtask

   task automatic gp1_word(input logic [31:0] v, inout gpu_result_type res);
      case (v[31:24])
         GP1_INIT: clear_gpu_state();
         GP1_FLUSH: begin
            words_left = '0; image_mode = 1'b0; word_pos = '0;
         end
         GP1_IRQ_ACK: off_irq_dma[1] = 1'b0;
         GP1_DISP_EN: off_irq_dma[0] = v[0];
         GP1_DMA_DIR: off_irq_dma[3:2] = v[1:0];
         GP1_VRAM_ST: begin
            vram_start = {v[18:10], v[9:1], 1'b0};
            compute_window(res);
         end
         GP1_HRANGE: begin
            ranges[23:0] = v[23:0];
            compute_window(res);
         end
         GP1_VRANGE: begin
            ranges[43:24] = v[19:0];
            compute_window(res);
         end
         GP1_DISP_MODE: begin
            disp_mode = {disp_mode[7], v[5:2], v[1:0], v[6]};
            if (v[7]) res.bad_mode = 1'b1;
         end
         default: res.unk = 1'b1;
      endcase
   endtask

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", field, got, want, $realtime);
      fail_count++;
   endtask

   always @(posedge clock) begin
      gpu_result_type res, got, want;
      if (reset) begin
         disp_mode = 8'h80;
         clear_gpu_state();
         image_size = '0; cmd_op = '0; cmd_unknown = 1'b0;
         status_expected_q.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            res = '0;
            if (req_tuser == KIND_GP0) gp0_word(req_tdata, res);
            else if (req_tuser == KIND_GP1) gp1_word(req_tdata, res);
            res.status = gpu_status_word();
            status_expected_q.push_back(res);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[97:0];
            if (status_expected_q.size() == 0) begin
               report_mismatch("unexpected transfer", got.status, 32'd0);
            end else begin
               want = status_expected_q.pop_front();
               if (got.status !== want.status)
                  report_mismatch("status_word", got.status, want.status);
               if (got.done !== want.done)
                  report_mismatch("command_done", 32'(got.done), 32'(want.done));
               if (got.op !== want.op)
                  report_mismatch("done_opcode", 32'(got.op), 32'(want.op));
               if (got.img !== want.img)
                  report_mismatch("image_data_word", 32'(got.img), 32'(want.img));
               if (got.unk !== want.unk)
                  report_mismatch("unknown_command", 32'(got.unk), 32'(want.unk));
               if (got.bad_mode !== want.bad_mode)
                  report_mismatch("bad_display_mode", 32'(got.bad_mode),
                                  32'(want.bad_mode));
               if (got.vp_upd !== want.vp_upd)
                  report_mismatch("viewport_update", 32'(got.vp_upd), 32'(want.vp_upd));
               if (got.vp_x !== want.vp_x)
                  report_mismatch("viewport_x", 32'(got.vp_x), 32'(want.vp_x));
               if (got.vp_y !== want.vp_y)
                  report_mismatch("viewport_y", 32'(got.vp_y), 32'(want.vp_y));
               if (got.vp_w !== want.vp_w)
                  report_mismatch("viewport_width", 32'(got.vp_w), 32'(want.vp_w));
               if (got.vp_h !== want.vp_h)
                  report_mismatch("viewport_height", 32'(got.vp_h), 32'(want.vp_h));
            end
         end
      end
      awaited_count <= status_expected_q.size();
   end
endmodule
`default_nettype wire

[dv/gpu_command_port_and_status_core_test.sv]
// stimulus and verdict for the gpu command port and status core
`default_nettype none
module gpu_command_port_and_status_core_test
   import gcps_pkg::*;
;
   timeunit 1ns;
   timeprecision 1ps;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [ReqUserWidth-1:0] req_tuser;   // access_kind
   logic [ReqDataWidth-1:0] req_tdata;   // data_word
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RspDataWidth-1:0] rsp_tdata;   // status_word .. viewport_height, zero fill
   logic                    take_ready;
   logic                    long_hold;
   int                      fail_count;
   int                      awaited_count;
   int                      accesses_sent;
   bit                      stimulus_done;

   gpu_command_port_and_status_core u_top (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata
   );

   gpu_command_port_and_status_checker u_checker (
      .clock, .reset, .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tdata, .fail_count, .awaited_count
   );

   assign rsp_tready = take_ready && !long_hold;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic int draw_gap();
      if ($urandom_range(0, 2) == 0) return 0;
      return $urandom_range(0, 14);
   endfunction

   task automatic send_access(input kind_type kind, input logic [31:0] word);
      int gap;
      gap = (accesses_sent % 150 < 40) ? 0 : draw_gap();
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= word;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      accesses_sent++;
      @(negedge clock);
   endtask

   task automatic send_command(input logic [7:0] op, input int args);
      send_access(KIND_GP0, {op, 24'($urandom)});
      repeat (args) send_access(KIND_GP0, $urandom);
   endtask

   task automatic send_image_load(input logic [15:0] w, input logic [15:0] h);
      int n;
      send_access(KIND_GP0, {OP_IMG_LOAD, 24'($urandom)});
      send_access(KIND_GP0, $urandom);
      send_access(KIND_GP0, {h, w});
      n = (w * h + 1) / 2;
      repeat (n) send_access(KIND_GP0, $urandom);
   endtask

   task automatic send_display_range();
      logic [11:0] hs;
      logic [9:0]  ls;
      hs = 12'($urandom);
      ls = 10'($urandom);
      if ($urandom_range(0, 3) == 0)
         send_access(KIND_GP1, $urandom);
      else if ($urandom_range(0, 1) == 0)
         send_access(KIND_GP1, {GP1_HRANGE, 12'(hs + $urandom_range(0, 1100)), hs});
      else
         send_access(KIND_GP1, {GP1_VRANGE, 4'($urandom), 10'(ls + $urandom_range(0, 560)),
                                ls});
   endtask

   task automatic send_random_sequence();
      logic [7:0] gp1_ops[9];
      gp1_ops = '{GP1_INIT, GP1_FLUSH, GP1_IRQ_ACK, GP1_DISP_EN, GP1_DMA_DIR,
                  GP1_VRAM_ST, GP1_HRANGE, GP1_VRANGE, GP1_DISP_MODE};
      case ($urandom_range(0, 13))
         0: send_command(OP_POLY3, 4);
         1: send_command(OP_POLY4T, 8);
         2: send_command(OP_POLY3G, 5);
         3: send_command(OP_POLY4G, 7);
         4: send_command(OP_IMG_SAVE, 2);
         5: send_image_load(16'($urandom_range(0, 6)), 16'($urandom_range(0, 6)));
         6: send_command(8'($urandom_range(OP_NOP, OP_CLEAR)), 0);
         7, 8: send_command(8'($urandom_range(OP_DRAW_MODE, OP_MASK)), 0);
         9: send_display_range();
         10: begin
            if ($urandom_range(0, 7) == 0) send_access(KIND_GP1, {gp1_ops[0], 24'($urandom)});
            else send_access(KIND_GP1, {gp1_ops[$urandom_range(1, 8)], 24'($urandom)});
         end
         11: send_access(KIND_POLL, $urandom);
         12: send_access(kind_type'($urandom_range(0, 1)), $urandom);
         default: begin
            // broken command cut off by a flush
            send_access(KIND_GP0, {OP_POLY4T, 24'($urandom)});
            repeat ($urandom_range(0, 4)) send_access(KIND_GP0, $urandom);
            send_access(KIND_GP1, {GP1_FLUSH, 24'($urandom)});
         end
      endcase
   endtask

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = '0;
      req_tdata = '0;
      accesses_sent = 0;
      stimulus_done = 1'b0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      send_access(KIND_POLL, 32'hffff_ffff);
      send_access(KIND_GP0, {OP_DRAW_MODE, 24'hff_ffff});
      send_access(KIND_GP0, {OP_DRAW_MODE, 24'h00_0100});
      send_access(KIND_GP0, {OP_TEX_WIN, 24'hff_ffff});
      send_access(KIND_GP0, {OP_AREA_TL, 24'hff_ffff});
      send_access(KIND_GP0, {OP_AREA_BR, 24'h00_0000});
      send_access(KIND_GP0, {OP_OFFSET, 24'hff_ffff});
      send_access(KIND_GP0, {OP_MASK, 24'hff_ffff});
      send_access(KIND_GP0, {OP_NOP, 24'h00_0000});
      send_access(KIND_GP0, 32'hffff_ffff);
      send_image_load(16'd0, 16'd9);
      send_image_load(16'd3, 16'd1);
      send_access(KIND_GP0, {OP_IMG_LOAD, 24'd0});
      send_access(KIND_GP0, 32'd0);
      send_access(KIND_GP0, 32'hffff_ffff);
      send_access(KIND_GP0, 32'h1234_5678);
      send_access(KIND_GP1, {GP1_FLUSH, 24'd0});
      send_access(KIND_GP1, {GP1_IRQ_ACK, 24'hff_ffff});
      send_access(KIND_GP1, {GP1_DISP_EN, 24'hff_fffe});
      send_access(KIND_GP1, {GP1_DMA_DIR, 24'hff_ffff});
      send_access(KIND_GP1, {GP1_VRAM_ST, 24'hff_ffff});
      send_access(KIND_GP1, {GP1_HRANGE, 24'h600_200});
      send_access(KIND_GP1, {GP1_VRANGE, 24'h08_0000});
      send_access(KIND_GP1, {GP1_DISP_MODE, 24'hff_ffff});
      send_access(KIND_GP1, 32'hffff_ffff);
      send_access(KIND_GP1, {GP1_INIT, 24'd0});
      while (accesses_sent < 625) send_random_sequence();
      req_tvalid <= 1'b0;
      stimulus_done = 1'b1;
   end

   initial begin
      int wait_cycles;
      take_ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         wait_cycles = draw_gap();
         if (wait_cycles != 0) begin
            take_ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         take_ready <= 1'b1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         @(negedge clock);
      end
   end

   initial begin
      long_hold = 1'b0;
      while (accesses_sent < 200) @(negedge clock);
      long_hold = 1'b1;
      repeat (300) @(negedge clock);
      long_hold = 1'b0;
   end

   initial begin
      int drain_cycles;
      drain_cycles = 0;
      while (!stimulus_done) @(posedge clock);
      while (awaited_count != 0 && drain_cycles < 5000) begin
         @(posedge clock);
         drain_cycles++;
      end
      repeat (20) @(posedge clock);
      if (fail_count == 0 && awaited_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
